[rtl/qalu_pkg.sv]
// Shared types, constants and the saturation helper for the quaternion ALU.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package qalu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  // Divider widths: numerator magnitude shifted up by the fraction bits,
  // denominator up to the largest squared norm.
  localparam int NUM_W     = DATA_W + FRAC_BITS;
  localparam int DEN_W     = 65 - FRAC_BITS;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_DIV,
    OP_CONJ,
    OP_INV,
    OP_ROT
  } op_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_LAST
  } dv_state_t;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    op_t  op;
    logic is_div;
    fx_t  aw;
    fx_t  ax;
    fx_t  ay;
    fx_t  az;
    fx_t  bw;
    fx_t  bx;
    fx_t  by;
    fx_t  bz;
    fx_t  s;
  } req_t;

  typedef struct packed {
    logic valid;
    fx_t  w;
    fx_t  x;
    fx_t  y;
    fx_t  z;
    logic dz;
    logic sat;
  } res_t;

  typedef struct packed {
    logic go;
    acc_t n0;
    acc_t n1;
    acc_t n2;
    acc_t n3;
    acc_t den;
  } div_req_t;

  typedef struct packed {
    fx_t  value;
    logic clip;
  } sat_t;

  function automatic sat_t sat32(acc_t v);
    sat_t r;
    if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
      r.value = FX_MAX;
      r.clip  = 1'b1;
    end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
      r.value = FX_MIN;
      r.clip  = 1'b1;
    end else begin
      r.value = v[DATA_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

[rtl/qalu_front.sv]
// Front end: takes requests, marks the ones that need the divider and
// queues them for the back end. Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  qalu_pkg::req_t  in_req,
  input  logic            pop,
  output logic            head_valid,
  output qalu_pkg::req_t  head
);
  import qalu_pkg::*;

  req_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              push;
  req_t              cls_req;

  assign busy       = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign push       = start && !busy;
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    cls_req        = in_req;
    cls_req.is_div = (in_req.op == OP_DIV) || (in_req.op == OP_INV);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls_req;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0 && cnt_r <= (QPTR_W+1)'(QDEPTH))
    else $error("queue popped while empty or count overflowed");
`endif

endmodule

[rtl/qalu_div.sv]
// Four-lane restoring divider, one quotient bit per lane per cycle, with
// sign handling and saturation of the quotients. Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  qalu_pkg::div_req_t req,
  output qalu_pkg::res_t     res
);
  import qalu_pkg::*;

  dv_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [DEN_W-1:0]  rem_r [4];
  logic [DEN_W-1:0]  rem_nxt [4];
  logic [NUM_W-1:0]  quo_r [4];
  logic [NUM_W-1:0]  quo_nxt [4];
  logic [3:0]        neg_r, neg_nxt;
  logic              dz_r, dz_nxt;
  logic              done_r, done_nxt;
  fx_t               val_r [4];
  fx_t               val_nxt [4];
  logic              clip_r, clip_nxt;

  acc_t              num_in [4];
  logic [DATA_W:0]   n33;
  logic [DATA_W:0]   nmag;
  acc_t              dabs;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;
  logic              hi;
  logic [3:0]        lclip;

  assign num_in[0] = req.n0;
  assign num_in[1] = req.n1;
  assign num_in[2] = req.n2;
  assign num_in[3] = req.n3;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    den_nxt   = den_r;
    neg_nxt   = neg_r;
    dz_nxt    = dz_r;
    done_nxt  = 1'b0;
    clip_nxt  = clip_r;
    n33       = '0;
    nmag      = '0;
    dabs      = '0;
    trial     = '0;
    diff      = '0;
    ge        = 1'b0;
    hi        = 1'b0;
    lclip     = '0;
    for (int i = 0; i < 4; i++) begin
      rem_nxt[i] = rem_r[i];
      quo_nxt[i] = quo_r[i];
      val_nxt[i] = val_r[i];
    end
    unique case (state_r)
      DV_IDLE: begin
        if (req.go) begin
          state_nxt = DV_RUN;
          cnt_nxt   = '0;
          dabs      = req.den[ACC_W-1] ? -req.den : req.den;
          den_nxt   = dabs[DEN_W-1:0];
          dz_nxt    = (req.den == '0);
          for (int i = 0; i < 4; i++) begin
            n33        = num_in[i][DATA_W:0];
            nmag       = n33[DATA_W] ? -n33 : n33;
            quo_nxt[i] = {nmag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
            rem_nxt[i] = '0;
            neg_nxt[i] = n33[DATA_W] ^ req.den[ACC_W-1];
          end
        end
      end
      DV_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        for (int i = 0; i < 4; i++) begin
          trial      = {rem_r[i], quo_r[i][NUM_W-1]};
          diff       = trial - {1'b0, den_r};
          ge         = (trial >= {1'b0, den_r});
          rem_nxt[i] = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo_nxt[i] = {quo_r[i][NUM_W-2:0], ge};
        end
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = DV_LAST;
        end
      end
      DV_LAST: begin
        state_nxt = DV_IDLE;
        done_nxt  = 1'b1;
        for (int i = 0; i < 4; i++) begin
          hi = |quo_r[i][NUM_W-1:DATA_W];
          if (neg_r[i]) begin
            lclip[i]   = hi || (quo_r[i][DATA_W-1] && (|quo_r[i][DATA_W-2:0]));
            val_nxt[i] = lclip[i] ? FX_MIN : -fx_t'(quo_r[i][DATA_W-1:0]);
          end else begin
            lclip[i]   = hi || quo_r[i][DATA_W-1];
            val_nxt[i] = lclip[i] ? FX_MAX : fx_t'(quo_r[i][DATA_W-1:0]);
          end
          if (dz_r) begin
            val_nxt[i] = '0;
          end
        end
        clip_nxt = !dz_r && (|lclip);
      end
      default: begin
        state_nxt = DV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    dz_r   <= dz_nxt;
    clip_r <= clip_nxt;
    for (int i = 0; i < 4; i++) begin
      rem_r[i] <= rem_nxt[i];
      quo_r[i] <= quo_nxt[i];
      val_r[i] <= val_nxt[i];
    end
  end

  assign res.valid = done_r;
  assign res.w     = val_r[0];
  assign res.x     = val_r[1];
  assign res.y     = val_r[2];
  assign res.z     = val_r[3];
  assign res.dz    = dz_r;
  assign res.sat   = clip_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.go |-> state_r == DV_IDLE)
    else $error("divider started while a division is in progress");
`endif

endmodule

[rtl/qalu_dpath.sv]
// Back end pipeline: issues queued requests, forms products, sums and the
// rotation, saturates, and hands divide and inverse to qalu_div.
// Depends on qalu_pkg.
`timescale 1ns / 1ps

module qalu_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  qalu_pkg::req_t     head,
  output logic               pop,
  input  logic               div_done,
  output qalu_pkg::div_req_t div_req,
  output qalu_pkg::res_t     res
);
  import qalu_pkg::*;

  logic div_busy_r, div_busy_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic v4_nxt;
  req_t r1_r, r2_r, r3_r, r4_r;

  fx_t  ma [16];
  fx_t  mb [16];
  acc_t p2_r [16];
  acc_t p2_nxt [16];
  acc_t f [16];

  acc_t acc3_r [4];
  acc_t acc3_nxt [4];
  acc_t den3_r, den3_nxt;
  fx_t  t3_r [3];
  fx_t  t3_nxt [3];
  logic clip3_r, clip3_nxt;
  sat_t tsat [3];

  acc_t g4_r [9];
  acc_t g4_nxt [9];
  acc_t acc4_r [4];
  logic clip4_r;
  acc_t h [9];

  acc_t acc5_r [4];
  acc_t acc5_nxt [4];
  logic clip5_r;
  logic is_rot5_r;

  sat_t osat [4];
  fx_t  out_r [4];
  logic osat_r, osat_nxt;

  // Issue is held while a divide or inverse is in flight to keep order.
  assign pop = head_valid && !div_busy_r;

  always_comb begin
    div_busy_nxt = div_busy_r;
    if (div_done) begin
      div_busy_nxt = 1'b0;
    end else if (pop && head.is_div) begin
      div_busy_nxt = 1'b1;
    end
  end

  // Product operands: first four change with the operation, rest are fixed.
  always_comb begin
    ma[0] = r1_r.aw; ma[1] = r1_r.ax; ma[2] = r1_r.ay; ma[3] = r1_r.az;
    unique case (r1_r.op)
      OP_MUL: begin
        mb[0] = r1_r.bw; mb[1] = r1_r.bx; mb[2] = r1_r.by; mb[3] = r1_r.bz;
      end
      OP_SCALE: begin
        mb[0] = r1_r.s; mb[1] = r1_r.s; mb[2] = r1_r.s; mb[3] = r1_r.s;
      end
      default: begin
        mb[0] = r1_r.aw; mb[1] = r1_r.ax; mb[2] = r1_r.ay; mb[3] = r1_r.az;
      end
    endcase
    ma[4]  = r1_r.aw; mb[4]  = r1_r.bx;
    ma[5]  = r1_r.bw; mb[5]  = r1_r.ax;
    ma[6]  = r1_r.ay; mb[6]  = r1_r.bz;
    ma[7]  = r1_r.az; mb[7]  = r1_r.by;
    ma[8]  = r1_r.aw; mb[8]  = r1_r.by;
    ma[9]  = r1_r.bw; mb[9]  = r1_r.ay;
    ma[10] = r1_r.az; mb[10] = r1_r.bx;
    ma[11] = r1_r.ax; mb[11] = r1_r.bz;
    ma[12] = r1_r.aw; mb[12] = r1_r.bz;
    ma[13] = r1_r.bw; mb[13] = r1_r.az;
    ma[14] = r1_r.ax; mb[14] = r1_r.by;
    ma[15] = r1_r.ay; mb[15] = r1_r.bx;
    for (int k = 0; k < 16; k++) begin
      p2_nxt[k] = ma[k] * mb[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      f[k] = p2_r[k] >>> FRAC_BITS;
    end
    tsat[0] = sat32((f[6] - f[7]) <<< 1);
    tsat[1] = sat32((f[10] - f[11]) <<< 1);
    tsat[2] = sat32((f[14] - f[15]) <<< 1);
    for (int k = 0; k < 3; k++) begin
      t3_nxt[k] = tsat[k].value;
    end
    clip3_nxt = (r2_r.op == OP_ROT) && (tsat[0].clip || tsat[1].clip || tsat[2].clip);
    den3_nxt  = '0;
    unique case (r2_r.op)
      OP_MUL: begin
        acc3_nxt[0] = f[0] - f[1] - f[2] - f[3];
        acc3_nxt[1] = f[4] + f[5] + f[6] - f[7];
        acc3_nxt[2] = f[8] + f[9] + f[10] - f[11];
        acc3_nxt[3] = f[12] + f[13] + f[14] - f[15];
      end
      OP_ADD: begin
        acc3_nxt[0] = acc_t'(r2_r.aw) + acc_t'(r2_r.bw);
        acc3_nxt[1] = acc_t'(r2_r.ax) + acc_t'(r2_r.bx);
        acc3_nxt[2] = acc_t'(r2_r.ay) + acc_t'(r2_r.by);
        acc3_nxt[3] = acc_t'(r2_r.az) + acc_t'(r2_r.bz);
      end
      OP_SUB: begin
        acc3_nxt[0] = acc_t'(r2_r.aw) - acc_t'(r2_r.bw);
        acc3_nxt[1] = acc_t'(r2_r.ax) - acc_t'(r2_r.bx);
        acc3_nxt[2] = acc_t'(r2_r.ay) - acc_t'(r2_r.by);
        acc3_nxt[3] = acc_t'(r2_r.az) - acc_t'(r2_r.bz);
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          acc3_nxt[i] = f[i];
        end
      end
      OP_DIV: begin
        acc3_nxt[0] = acc_t'(r2_r.aw);
        acc3_nxt[1] = acc_t'(r2_r.ax);
        acc3_nxt[2] = acc_t'(r2_r.ay);
        acc3_nxt[3] = acc_t'(r2_r.az);
        den3_nxt    = acc_t'(r2_r.s);
      end
      OP_CONJ, OP_INV: begin
        acc3_nxt[0] = acc_t'(r2_r.aw);
        acc3_nxt[1] = -acc_t'(r2_r.ax);
        acc3_nxt[2] = -acc_t'(r2_r.ay);
        acc3_nxt[3] = -acc_t'(r2_r.az);
        den3_nxt    = f[0] + f[1] + f[2] + f[3];
      end
      OP_ROT: begin
        for (int i = 0; i < 4; i++) begin
          acc3_nxt[i] = '0;
        end
      end
      default: begin
        for (int i = 0; i < 4; i++) begin
          acc3_nxt[i] = '0;
        end
      end
    endcase
  end

  assign div_req.go  = v3_r && r3_r.is_div;
  assign div_req.n0  = acc3_r[0];
  assign div_req.n1  = acc3_r[1];
  assign div_req.n2  = acc3_r[2];
  assign div_req.n3  = acc3_r[3];
  assign div_req.den = den3_r;

  // Divider items leave the pipeline here.
  assign v4_nxt = v3_r && !r3_r.is_div;

  always_comb begin
    g4_nxt[0] = r3_r.aw * t3_r[0];
    g4_nxt[1] = r3_r.ay * t3_r[2];
    g4_nxt[2] = r3_r.az * t3_r[1];
    g4_nxt[3] = r3_r.aw * t3_r[1];
    g4_nxt[4] = r3_r.az * t3_r[0];
    g4_nxt[5] = r3_r.ax * t3_r[2];
    g4_nxt[6] = r3_r.aw * t3_r[2];
    g4_nxt[7] = r3_r.ax * t3_r[1];
    g4_nxt[8] = r3_r.ay * t3_r[0];
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      h[k] = g4_r[k] >>> FRAC_BITS;
    end
    if (r4_r.op == OP_ROT) begin
      acc5_nxt[0] = '0;
      acc5_nxt[1] = acc_t'(r4_r.bx) + h[0] + h[1] - h[2];
      acc5_nxt[2] = acc_t'(r4_r.by) + h[3] + h[4] - h[5];
      acc5_nxt[3] = acc_t'(r4_r.bz) + h[6] + h[7] - h[8];
    end else begin
      for (int i = 0; i < 4; i++) begin
        acc5_nxt[i] = acc4_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      osat[i] = sat32(acc5_r[i]);
    end
    osat_nxt = clip5_r || osat[0].clip || osat[1].clip || osat[2].clip || osat[3].clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      v4_r       <= 1'b0;
      v5_r       <= 1'b0;
      v6_r       <= 1'b0;
    end else begin
      div_busy_r <= div_busy_nxt;
      v1_r       <= pop;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      v4_r       <= v4_nxt;
      v5_r       <= v4_r;
      v6_r       <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_r      <= head;
    r2_r      <= r1_r;
    r3_r      <= r2_r;
    r4_r      <= r3_r;
    den3_r    <= den3_nxt;
    clip3_r   <= clip3_nxt;
    clip4_r   <= clip3_r;
    clip5_r   <= clip4_r;
    is_rot5_r <= (r4_r.op == OP_ROT);
    osat_r    <= osat_nxt;
    for (int k = 0; k < 16; k++) begin
      p2_r[k] <= p2_nxt[k];
    end
    for (int k = 0; k < 3; k++) begin
      t3_r[k] <= t3_nxt[k];
    end
    for (int k = 0; k < 9; k++) begin
      g4_r[k] <= g4_nxt[k];
    end
    for (int i = 0; i < 4; i++) begin
      acc3_r[i] <= acc3_nxt[i];
      acc4_r[i] <= acc3_r[i];
      acc5_r[i] <= acc5_nxt[i];
      out_r[i]  <= osat[i].value;
    end
  end

  assign res.valid = v6_r;
  assign res.w     = out_r[0];
  assign res.x     = out_r[1];
  assign res.y     = out_r[2];
  assign res.z     = out_r[3];
  assign res.dz    = 1'b0;
  assign res.sat   = osat_r;

`ifndef SYNTHESIS
  a_rot_clip_only: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !is_rot5_r |-> !clip5_r)
    else $error("intermediate clip flagged on a non-rotate request");
`endif

endmodule

[rtl/quaternion_alu_core.sv]
// Quaternion ALU top level: Q16.16 product, sum, difference, scale,
// divide, conjugate, inverse and vector rotation. Depends on qalu_pkg,
// qalu_front, qalu_dpath and qalu_div.
//
// Use: drive the in_ ports and raise start; a request transfers at a rising
// edge where start is high and busy is low. busy rises only when the
// four-entry request queue is full.
// Each request gives one result, in request order, on the out_ ports for
// exactly one cycle with out_valid high; the receiver cannot stall it.
// Multiply, add, subtract, scale, conjugate and rotate go through the
// six-stage multiply/add pipeline; these sustain one request per cycle
// while no divide or inverse holds issue.
// Divide and inverse go through a restoring divider that makes one quotient
// bit per cycle, 32 + FRAC_BITS bits per lane. Requests behind a divide or
// inverse wait in the queue until its result leaves.
// Division by zero returns zeros with out_div_zero set.
// Reset (rst_n low, synchronous) empties the queue and clears all valid
// flags; no result is produced until new requests arrive.
`timescale 1ns / 1ps

module quaternion_alu_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          in_req_type,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_a_w,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_a_x,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_a_y,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_a_z,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_b_w,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_b_x,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_b_y,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_b_z,
  input  logic signed [qalu_pkg::DATA_W-1:0]  in_scalar,
  output logic                                out_valid,
  output logic signed [qalu_pkg::DATA_W-1:0]  out_res_w,
  output logic signed [qalu_pkg::DATA_W-1:0]  out_res_x,
  output logic signed [qalu_pkg::DATA_W-1:0]  out_res_y,
  output logic signed [qalu_pkg::DATA_W-1:0]  out_res_z,
  output logic                                out_div_zero,
  output logic                                out_saturated
);
  import qalu_pkg::*;

  req_t     in_req;
  req_t     head;
  logic     head_valid;
  logic     pop;
  div_req_t div_req;
  res_t     dp_res;
  res_t     dv_res;
  res_t     sel_res;

  always_comb begin
    in_req.op     = op_t'(in_req_type);
    in_req.is_div = 1'b0;
    in_req.aw     = in_a_w;
    in_req.ax     = in_a_x;
    in_req.ay     = in_a_y;
    in_req.az     = in_a_z;
    in_req.bw     = in_b_w;
    in_req.bx     = in_b_x;
    in_req.by     = in_b_y;
    in_req.bz     = in_b_z;
    in_req.s      = in_scalar;
  end

  qalu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  qalu_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .div_done   (dv_res.valid),
    .div_req    (div_req),
    .res        (dp_res)
  );

  qalu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (dv_res)
  );

  // Issue order guarantees the two sources never finish together.
  assign sel_res = dv_res.valid ? dv_res : dp_res;

  assign out_valid     = sel_res.valid;
  assign out_res_w     = sel_res.w;
  assign out_res_x     = sel_res.x;
  assign out_res_y     = sel_res.y;
  assign out_res_z     = sel_res.z;
  assign out_div_zero  = sel_res.dz;
  assign out_saturated = sel_res.sat;

`ifndef SYNTHESIS
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_res.valid && dv_res.valid))
    else $error("pipeline and divider results collided");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |->
      out_res_w == '0 && out_res_x == '0 && out_res_y == '0 &&
      out_res_z == '0 && !out_saturated)
    else $error("division by zero result not cleared");
`endif

endmodule
